// ===== hdl/lpd_pkg.sv =====
// Shared types and constants for the length-prefixed deframer.
package lpd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned LenW  = 16;
  localparam int unsigned CfgIndexW = 2;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned OutDataW  = ByteW + LenW + LenW;

  localparam logic [ByteW-1:0] StartByteReset = 8'h00;
  localparam logic [LenW-1:0]  MaxLengthReset = 16'd1024;

  localparam logic [CfgIndexW-1:0] CfgStartByte = 2'd0;
  localparam logic [CfgIndexW-1:0] CfgMaxLength = 2'd1;

  localparam logic [1:0] PhaseHunt    = 2'd0;
  localparam logic [1:0] PhaseLenHi   = 2'd1;
  localparam logic [1:0] PhaseLenLo   = 2'd2;
  localparam logic [1:0] PhasePayload = 2'd3;

  typedef struct packed {
    logic            payload_valid;
    logic [ByteW-1:0] payload_byte;
    logic [LenW-1:0]  payload_index;
    logic            frame_done;
    logic [LenW-1:0]  frame_length;
  } lpd_result_t;

endpackage

// ===== hdl/lpd_frame_fsm.sv =====
// Frame parser: phase, length and count registers and the per-byte result.
module lpd_frame_fsm (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  logic [lpd_pkg::ByteW-1:0]  byte_i,
  input  logic [lpd_pkg::ByteW-1:0]  start_byte_i,
  input  logic [lpd_pkg::LenW-1:0]   max_length_i,
  output lpd_pkg::lpd_result_t       res_o
);
  import lpd_pkg::*;

  logic [1:0]      phase_q, phase_d;
  logic [LenW-1:0] len_q, len_d;
  logic [LenW-1:0] cnt_q, cnt_d;
  logic [LenW-1:0] len_full;
  logic [LenW-1:0] cnt_inc;

  assign len_full = {len_q[LenW-1:ByteW], byte_i};
  assign cnt_inc  = cnt_q + LenW'(1);

  always_comb begin
    phase_d = phase_q;
    len_d   = len_q;
    cnt_d   = cnt_q;
    res_o   = '0;
    unique case (phase_q)
      PhaseHunt: begin
        if (byte_i == start_byte_i) begin
          phase_d = PhaseLenHi;
        end
      end
      PhaseLenHi: begin
        len_d   = {byte_i, {ByteW{1'b0}}};
        phase_d = PhaseLenLo;
      end
      PhaseLenLo: begin
        len_d = len_full;
        cnt_d = '0;
        if ((len_full == '0) || (len_full > max_length_i)) begin
          phase_d = PhaseHunt;
        end else begin
          phase_d = PhasePayload;
        end
      end
      PhasePayload: begin
        res_o.payload_valid = 1'b1;
        res_o.payload_byte  = byte_i;
        res_o.payload_index = cnt_q;
        cnt_d = cnt_inc;
        if (cnt_inc == len_q) begin
          res_o.frame_done   = 1'b1;
          res_o.frame_length = len_q;
          phase_d = PhaseHunt;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhaseHunt;
      len_q   <= '0;
      cnt_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
    end
  end

  a_count_below_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhasePayload) |-> (cnt_q < len_q))
    else $error("Payload count reached the frame length without closing the frame.");

  a_length_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhasePayload) |-> (len_q != '0))
    else $error("Payload phase entered with a zero length.");

  a_done_returns_to_hunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && res_o.frame_done) |=> (phase_q == PhaseHunt))
    else $error("Frame end did not return the parser to the hunt.");

endmodule

// ===== hdl/length_prefixed_deframer_core.sv =====
// Top level of the length-prefixed deframer: channels, config registers, pipeline.
//
// Channel   Direction  Handshake                    Content
// s_axis    in         s_axis_tvalid/tready         one received byte
// m_axis    out        m_axis_tvalid/tready         one result item per byte
// cfg       in         cfg_valid_i/cfg_ready_o      register index and data
//
// Each byte passes an input register and a result register, and one item per cycle
// is sustained while m_axis_tready is high.
// The parser state advances when the input register moves into the result register.
// Reset returns the parser to the hunt and loads the register reset values.
// A stall on m_axis holds the result register and then the input register.
module length_prefixed_deframer_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [lpd_pkg::ByteW-1:0]     s_axis_tdata,     // [7:0] rx_byte
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [7:0] payload_byte, [23:8] payload_index, [39:24] frame_length
  output logic [lpd_pkg::OutDataW-1:0]  m_axis_tdata,
  output logic                          m_axis_tuser,     // [0] payload_valid
  output logic                          m_axis_tlast,     // frame_done
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lpd_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [lpd_pkg::CfgDataW-1:0]  cfg_data_i
);
  import lpd_pkg::*;

  logic [ByteW-1:0] start_byte_q;
  logic [LenW-1:0]  max_length_q;
  logic             in_valid_q;
  logic [ByteW-1:0] in_byte_q;
  logic             out_valid_q;
  lpd_result_t      out_q;
  lpd_result_t      res;
  logic             advance;
  logic             cfg_write;

  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_byte_q <= StartByteReset;
      max_length_q <= MaxLengthReset;
    end else if (cfg_write) begin
      unique case (cfg_index_i)
        CfgStartByte: start_byte_q <= cfg_data_i[ByteW-1:0];
        CfgMaxLength: max_length_q <= cfg_data_i[LenW-1:0];
        default: begin
        end
      endcase
    end
  end

  assign advance       = in_valid_q & (~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~in_valid_q | advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  lpd_frame_fsm u_fsm (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .byte_i       (in_byte_q),
    .start_byte_i (start_byte_q),
    .max_length_i (max_length_q),
    .res_o        (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.frame_length, out_q.payload_index, out_q.payload_byte};
  assign m_axis_tuser  = out_q.payload_valid;
  assign m_axis_tlast  = out_q.frame_done;

  a_last_is_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.frame_done) |-> out_q.payload_valid)
    else $error("Frame end flagged on a byte that is not payload.");

  a_idle_result_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.payload_valid) |-> (m_axis_tdata == '0))
    else $error("Non-payload result carries nonzero fields.");

  a_length_only_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.frame_done) |-> (out_q.frame_length == '0))
    else $error("Frame length shown before the frame end.");

endmodule

// ===== bench/length_prefixed_deframer_checker.sv =====
// Checker for the deframer: watches all three channels, predicts every result item and compares.
`timescale 1ns / 100ps
module length_prefixed_deframer_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          rx_valid_i,
  input  logic                          rx_ready_i,
  input  logic [lpd_pkg::ByteW-1:0]     rx_byte_i,
  input  logic                          res_valid_i,
  input  logic                          res_ready_i,
  input  logic [lpd_pkg::OutDataW-1:0]  res_data_i,
  input  logic                          res_user_i,
  input  logic                          res_last_i,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [lpd_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [lpd_pkg::CfgDataW-1:0]  cfg_data_i,
  output int                            fail_count_o,
  output int                            pending_o
);
  import lpd_pkg::*;

  logic [ByteW-1:0] start_reg;
  logic [LenW-1:0]  max_reg;
  logic [1:0]       parse_phase;
  logic [LenW-1:0]  frame_len;
  logic [LenW-1:0]  byte_count;
  lpd_result_t      expected_results[$];

  function automatic lpd_result_t parse_rx_byte(input logic [ByteW-1:0] b);
    lpd_result_t r;
    r = '0;
    case (parse_phase)
      PhaseHunt: begin
        if (b == start_reg) parse_phase = PhaseLenHi;
      end
      PhaseLenHi: begin
        frame_len = {b, 8'h00};
        parse_phase = PhaseLenLo;
      end
      PhaseLenLo: begin
        frame_len = {frame_len[15:8], b};
        byte_count = '0;
        if (frame_len == '0 || frame_len > max_reg) parse_phase = PhaseHunt;
        else parse_phase = PhasePayload;
      end
      default: begin
        r.payload_valid = 1'b1;
        r.payload_byte = b;
        r.payload_index = byte_count;
        byte_count = byte_count + 1'b1;
        if (byte_count == frame_len) begin
          r.frame_done = 1'b1;
          r.frame_length = frame_len;
          parse_phase = PhaseHunt;
        end
      end
    endcase
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [LenW-1:0] want_v,
                                      input logic [LenW-1:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      fail_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    lpd_result_t want;
    if (!rst_ni) begin
      start_reg = StartByteReset;
      max_reg = MaxLengthReset;
      parse_phase = PhaseHunt;
      frame_len = '0;
      byte_count = '0;
      expected_results.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CfgStartByte) start_reg = cfg_data_i[ByteW-1:0];
        else if (cfg_index_i == CfgMaxLength) max_reg = cfg_data_i;
      end
      if (res_valid_i && res_ready_i) begin
        if (expected_results.size() == 0) begin
          $error("result item arrived with no item pending");
          fail_count_o++;
        end else begin
          want = expected_results.pop_front();
          check_field("payload_valid", LenW'(want.payload_valid), LenW'(res_user_i));
          check_field("payload_byte", LenW'(want.payload_byte), LenW'(res_data_i[7:0]));
          check_field("payload_index", want.payload_index, res_data_i[23:8]);
          check_field("frame_done", LenW'(want.frame_done), LenW'(res_last_i));
          check_field("frame_length", want.frame_length, res_data_i[39:24]);
        end
      end
      if (rx_valid_i && rx_ready_i) expected_results.push_back(parse_rx_byte(rx_byte_i));
    end
    pending_o = expected_results.size();
  end

endmodule

// ===== bench/length_prefixed_deframer_core_tb.sv =====
// Testbench top for the deframer: reset, register setup, byte stimulus and the verdict.
`timescale 1ns / 100ps
module length_prefixed_deframer_core_tb;
  import lpd_pkg::*;

  localparam int unsigned RandomItems = 650;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned HoldCycles  = 300;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [ByteW-1:0]     s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutDataW-1:0]  m_axis_tdata;
  logic                 m_axis_tuser;
  logic                 m_axis_tlast;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIndexW-1:0] cfg_index_i = CfgStartByte;
  logic [CfgDataW-1:0]  cfg_data_i = '0;

  int fail_count;
  int pending;
  int sent_count = 0;
  int burst_left = 0;
  int cycle_count = 0;

  logic [ByteW-1:0] byte_list[$];
  logic [ByteW-1:0] start_sel;
  logic [LenW-1:0]  max_sel;

  length_prefixed_deframer_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  length_prefixed_deframer_checker result_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rx_valid_i   (s_axis_tvalid),
    .rx_ready_i   (s_axis_tready),
    .rx_byte_i    (s_axis_tdata),
    .res_valid_i  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_data_i   (m_axis_tdata),
    .res_user_i   (m_axis_tuser),
    .res_last_i   (m_axis_tlast),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_rx(input logic [ByteW-1:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
    end
    s_axis_tdata <= b;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    burst_left--;
    sent_count++;
  endtask

  task automatic send_list;
    foreach (byte_list[i]) send_rx(byte_list[i]);
  endtask

  task automatic wait_idle;
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic configure(input logic [ByteW-1:0] sb, input logic [LenW-1:0] ml);
    logic       max_first;
    logic [7:0] junk;
    max_first = 1'($urandom_range(0, 1));
    for (int k = 0; k < 2; k++) begin
      junk = 8'($urandom);
      if ((k == 0) == max_first) begin
        cfg_index_i <= CfgMaxLength;
        cfg_data_i <= ml;
      end else begin
        cfg_index_i <= CfgStartByte;
        cfg_data_i <= {junk, sb};
      end
      cfg_valid_i <= 1'b1;
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
    start_sel = sb;
    max_sel = ml;
  endtask

  task automatic send_frame(input logic clean);
    int               plen;
    int               pick;
    int               top_len;
    logic [LenW-1:0]  flen;
    logic [ByteW-1:0] b;
    repeat ($urandom_range(0, 2)) begin
      b = 8'($urandom);
      if (clean && b == start_sel) b = b ^ 8'h01;
      send_rx(b);
    end
    send_rx(start_sel);
    pick = $urandom_range(0, 9);
    plen = 0;
    if (max_sel == '0) begin
      flen = LenW'($urandom);
    end else if (pick == 7) begin
      flen = '0;
    end else if (pick >= 8 && max_sel != 16'hFFFF) begin
      if (pick == 8) flen = max_sel + 1'b1;
      else flen = LenW'($urandom_range(int'(max_sel) + 1, 65535));
    end else begin
      top_len = (max_sel < 40) ? int'(max_sel) : 40;
      flen = LenW'($urandom_range(1, top_len));
      plen = int'(flen);
    end
    send_rx(flen[15:8]);
    send_rx(flen[7:0]);
    // A cut-short payload makes the parser swallow the next frame's header as data.
    if (!clean && plen > 0 && $urandom_range(0, 9) == 0) begin
      plen = int'($urandom_range(0, plen - 1));
    end
    repeat (plen) begin
      b = ($urandom_range(0, 7) == 0) ? start_sel : 8'($urandom);
      send_rx(b);
    end
  endtask

  // Receiver: stall patterns that change from span to span, plus one long hold.
  initial begin
    int   mode;
    int   span;
    int   tick;
    logic held;
    held = 1'b0;
    tick = 0;
    @(posedge rst_ni);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(30, 200);
      repeat (span) begin
        @(posedge clk_i);
        tick++;
        if (!held && sent_count >= 80) begin
          held = 1'b1;
          m_axis_tready <= 1'b0;
          repeat (HoldCycles) @(posedge clk_i);
        end
        case (mode)
          0: begin
            m_axis_tready <= 1'b1;
          end
          1: begin
            m_axis_tready <= 1'($urandom_range(0, 1));
          end
          2: begin
            m_axis_tready <= (tick % 4 == 0);
          end
          default: begin
            m_axis_tready <= ($urandom_range(0, 6) != 0);
          end
        endcase
      end
    end
  end

  initial begin
    int   directed_count;
    int   phase_no;
    int   pick;
    logic [LenW-1:0] ml;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    start_sel = StartByteReset;
    max_sel = MaxLengthReset;
    byte_list = {8'h33, 8'h00, 8'h00, 8'h00, 8'h00, 8'h04, 8'h01,
                 8'h00, 8'h00, 8'h02, 8'h00, 8'hFF};
    send_list();
    wait_idle();

    configure(8'hFF, 16'd1);
    byte_list = {8'h00, 8'hFF, 8'h00, 8'h01, 8'h7E, 8'hFF, 8'h00, 8'h02,
                 8'hFF, 8'hFF, 8'hFF};
    send_list();
    wait_idle();

    configure(8'h80, 16'd0);
    byte_list = {8'h80, 8'h00, 8'h01};
    send_list();
    wait_idle();

    // The registers change while a frame is in progress; the frame must complete as announced.
    configure(8'h5A, 16'hFFFF);
    byte_list = {8'h5A, 8'h00, 8'h03, 8'h11};
    send_list();
    wait_idle();
    configure(8'h11, 16'd1);
    byte_list = {8'h5A, 8'h22};
    send_list();
    directed_count = sent_count;

    phase_no = 0;
    while (sent_count < directed_count + RandomItems) begin
      wait_idle();
      if (phase_no == 0) begin
        ml = 16'hFFFF;
      end else if (phase_no == 1) begin
        ml = LenW'($urandom_range(301, 65534));
      end else begin
        pick = $urandom_range(0, 9);
        if (pick == 0) ml = '0;
        else if (pick == 1) ml = 16'd1;
        else ml = LenW'($urandom_range(2, 300));
      end
      configure(8'($urandom), ml);
      repeat ($urandom_range(3, 10)) send_frame(max_sel > 300);
      phase_no++;
    end

    wait_idle();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/lpd_pkg.sv
hdl/lpd_frame_fsm.sv
hdl/length_prefixed_deframer_core.sv
bench/length_prefixed_deframer_checker.sv
bench/length_prefixed_deframer_core_tb.sv
